FILE: sv/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants, codes and types of the bitmap page allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package bpa_pkg;

  localparam int MAX_PAGES      = 4096;
  localparam int PAGE_BYTES     = 4096;
  localparam int SCAN_WORD_BITS = 64;

  localparam int ADDR_W     = 48;
  localparam int CNT_W      = $clog2(MAX_PAGES + 1);
  localparam int IDX_W      = $clog2(MAX_PAGES);
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int WORD_W     = SCAN_WORD_BITS;
  localparam int BIT_W      = $clog2(SCAN_WORD_BITS);
  localparam int ROW_W      = IDX_W - BIT_W;
  localparam int ROWS       = MAX_PAGES / SCAN_WORD_BITS;
  localparam int REG_W      = 1;

  localparam logic [1:0] MODE_RSV_ONE = 2'd0;
  localparam logic [1:0] MODE_REL_ONE = 2'd1;
  localparam logic [1:0] MODE_RSV_RUN = 2'd2;
  localparam logic [1:0] MODE_REL_RUN = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_ADDR = 2'd2;
  localparam logic [1:0] ST_LEN  = 2'd3;

  localparam logic [REG_W-1:0] REG_BASE  = 1'b0;
  localparam logic [REG_W-1:0] REG_COUNT = 1'b1;

  typedef struct packed {
    logic              re;
    logic              we;
    logic [ROW_W-1:0]  row;
    logic [WORD_W-1:0] wdata;
  } mem_req_t;

  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] pc);
    return (pc > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : pc;
  endfunction

endpackage
`default_nettype wire

FILE: sv/bpa_ifs.sv
// ----------------------------------------------------------------------------
// bpa channel interfaces
// Request, response and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none
interface bpa_req_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   mode;
  logic [bpa_pkg::ADDR_W-1:0]   page_address;
  logic [bpa_pkg::CNT_W-1:0]    run_length;
  modport source (output valid, mode, page_address, run_length, input ready);
  modport sink   (input valid, mode, page_address, run_length, output ready);
endinterface

interface bpa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [bpa_pkg::ADDR_W-1:0]   result_address;
  logic [1:0]                   status;
  logic [bpa_pkg::CNT_W-1:0]    free_left;
  modport source (output valid, result_address, status, free_left, input ready);
  modport sink   (input valid, result_address, status, free_left, output ready);
endinterface

interface bpa_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [bpa_pkg::REG_W-1:0]    index;
  logic [bpa_pkg::ADDR_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: sv/bpa_bitmap.sv
// ----------------------------------------------------------------------------
// bpa_bitmap
// Used-page bitmap: one word per row, registered read, per-row valid bits.
// ----------------------------------------------------------------------------
`default_nettype none
module bpa_bitmap (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       clr,
  input  wire bpa_pkg::mem_req_t          mreq,
  output logic [bpa_pkg::WORD_W-1:0]      rdata
);

  logic [bpa_pkg::WORD_W-1:0] mem [bpa_pkg::ROWS];
  logic [bpa_pkg::ROWS-1:0]   row_valid;
  logic [bpa_pkg::WORD_W-1:0] rd_q;
  logic                       rv_q;

  always_ff @(posedge clk) begin
    if (mreq.we) begin
      mem[mreq.row] <= mreq.wdata;
    end
    if (mreq.re) begin
      rd_q <= mem[mreq.row];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      row_valid <= '0;
      rv_q      <= 1'b0;
    end else begin
      if (mreq.we) begin
        row_valid[mreq.row] <= 1'b1;
      end
      if (mreq.re) begin
        rv_q <= row_valid[mreq.row];
      end
    end
  end

  assign rdata = rv_q ? rd_q : '0;

endmodule
`default_nettype wire

FILE: sv/bitmap_page_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// First-fit page allocator over a used-page bitmap with a free counter.
// ----------------------------------------------------------------------------
// Reserve one: reads and checks bitmap words in turn until one has a free bit.
// Release: per page, a range check and word read, then a write that clears its bit. Reserve run:
// scans one page per cycle, loading each word before its pages, then reads and marks each word.
// One item at a time; the bitmap read port sets the pace.
// Reset (rst, synchronous): base 0, page count 4096, all pages free.
// ----------------------------------------------------------------------------
`default_nettype none
module bitmap_page_allocator (
  input  wire logic   clk,
  input  wire logic   rst,
  bpa_cfg_if.sink     cfg,
  bpa_req_if.sink     req,
  bpa_rsp_if.source   rsp
);

  localparam int AW = bpa_pkg::ADDR_W;
  localparam int CW = bpa_pkg::CNT_W;
  localparam int IW = bpa_pkg::IDX_W;
  localparam int BW = bpa_pkg::BIT_W;
  localparam int RW = bpa_pkg::ROW_W;
  localparam int WW = bpa_pkg::WORD_W;
  localparam int PS = bpa_pkg::PAGE_SHIFT;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ORD   = 4'd1;
  localparam logic [3:0] S_OCHK  = 4'd2;
  localparam logic [3:0] S_PCHK  = 4'd3;
  localparam logic [3:0] S_PRW   = 4'd4;
  localparam logic [3:0] S_RRD   = 4'd5;
  localparam logic [3:0] S_RSCAN = 4'd6;
  localparam logic [3:0] S_MRD   = 4'd7;
  localparam logic [3:0] S_MWR   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]    state;
  logic [AW-1:0] base;
  logic [CW-1:0] page_count;
  logic [CW-1:0] free_cnt;
  logic [AW:0]   addr_q;
  logic [CW-1:0] rem_q;
  logic [CW-1:0] len_q;
  logic [CW-1:0] run_q;
  logic [IW-1:0] i_q;
  logic [IW-1:0] pidx_q;
  logic [IW-1:0] start_q;
  logic [IW-1:0] end_q;
  logic [RW-1:0] w_q;
  logic [AW-1:0] res_addr;
  logic [1:0]    res_status;
  logic          out_valid;
  logic [AW-1:0] out_addr;
  logic [1:0]    out_status;
  logic [CW-1:0] out_free;

  logic [CW-1:0] eff;
  logic          cfg_wr;
  logic          clr;
  logic          accept;
  logic          slot_free;
  logic [WW-1:0] rdata;
  bpa_pkg::mem_req_t mreq;

  logic [AW:0]   diff;
  logic          page_ok;
  logic [BW-1:0] zpos;
  logic          bit_used;
  logic [CW-1:0] run_n;
  logic [CW-1:0] start_n;
  logic [BW-1:0] lo;
  logic [BW-1:0] hi;
  logic [WW-1:0] mask;

  function automatic logic [BW-1:0] low_zero(input logic [WW-1:0] d);
    logic [BW-1:0] p;
    p = '0;
    for (int k = WW - 1; k >= 0; k--) begin
      if (!d[k]) p = BW'(k);
    end
    return p;
  endfunction

  function automatic logic [AW-1:0] page_addr(input logic [AW-1:0] b,
                                              input logic [IW-1:0] idx);
    return b + {{(AW-IW-PS){1'b0}}, idx, {PS{1'b0}}};
  endfunction

  assign eff       = bpa_pkg::eff_count(page_count);
  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid && cfg.ready;
  assign clr       = cfg_wr && (cfg.index == bpa_pkg::REG_COUNT);
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign slot_free = !out_valid || rsp.ready;

  assign rsp.valid          = out_valid;
  assign rsp.result_address = out_addr;
  assign rsp.status         = out_status;
  assign rsp.free_left      = out_free;

  assign diff     = addr_q - {1'b0, base};
  assign page_ok  = (addr_q[PS-1:0] == '0) && (addr_q >= {1'b0, base})
                    && (diff[AW:PS] < (AW+1-PS)'(eff));
  assign zpos     = low_zero(rdata);
  assign bit_used = rdata[i_q[BW-1:0]];
  assign run_n    = bit_used ? '0 : run_q + 1'b1;
  assign start_n  = {1'b0, i_q} + 1'b1 - len_q;
  assign lo       = (w_q == start_q[IW-1:BW]) ? start_q[BW-1:0] : '0;
  assign hi       = (w_q == end_q[IW-1:BW]) ? end_q[BW-1:0] : '1;
  assign mask     = ({WW{1'b1}} << lo) & ({WW{1'b1}} >> (BW'(WW - 1) - hi));

  always_comb begin
    mreq = '0;
    case (state)
      S_ORD: begin
        mreq.re  = 1'b1;
        mreq.row = w_q;
      end
      S_OCHK: begin
        mreq.we    = !(&rdata);
        mreq.row   = w_q;
        mreq.wdata = rdata | (WW'(1) << zpos);
      end
      S_PCHK: begin
        mreq.re  = page_ok;
        mreq.row = diff[PS+IW-1:PS+BW];
      end
      S_PRW: begin
        mreq.we    = rdata[pidx_q[BW-1:0]];
        mreq.row   = pidx_q[IW-1:BW];
        mreq.wdata = rdata & ~(WW'(1) << pidx_q[BW-1:0]);
      end
      S_RRD: begin
        mreq.re  = 1'b1;
        mreq.row = i_q[IW-1:BW];
      end
      S_MRD: begin
        mreq.re  = 1'b1;
        mreq.row = w_q;
      end
      S_MWR: begin
        mreq.we    = 1'b1;
        mreq.row   = w_q;
        mreq.wdata = rdata | mask;
      end
      default: mreq = '0;
    endcase
  end

  bpa_bitmap u_bitmap (
    .clk   (clk),
    .rst   (rst),
    .clr   (clr),
    .mreq  (mreq),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      base       <= '0;
      page_count <= CW'(bpa_pkg::MAX_PAGES);
      free_cnt   <= CW'(bpa_pkg::MAX_PAGES);
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && (state != S_DONE)) out_valid <= 1'b0;
      if (cfg_wr) begin
        if (cfg.index == bpa_pkg::REG_BASE) begin
          base <= cfg.data;
        end else begin
          page_count <= cfg.data[CW-1:0];
          free_cnt   <= bpa_pkg::eff_count(cfg.data[CW-1:0]);
        end
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_addr <= '0;
            addr_q   <= {1'b0, req.page_address};
            len_q    <= req.run_length;
            i_q      <= '0;
            run_q    <= '0;
            w_q      <= '0;
            case (req.mode)
              bpa_pkg::MODE_RSV_ONE: begin
                if (free_cnt == '0) begin
                  res_status <= bpa_pkg::ST_NONE;
                  state      <= S_DONE;
                end else begin
                  state <= S_ORD;
                end
              end
              bpa_pkg::MODE_REL_ONE: begin
                rem_q <= CW'(1);
                state <= S_PCHK;
              end
              bpa_pkg::MODE_RSV_RUN: begin
                if (req.run_length == '0 || req.run_length > eff) begin
                  res_status <= bpa_pkg::ST_LEN;
                  state      <= S_DONE;
                end else if (req.run_length > free_cnt) begin
                  res_status <= bpa_pkg::ST_NONE;
                  state      <= S_DONE;
                end else begin
                  state <= S_RRD;
                end
              end
              default: begin
                if (req.run_length == '0 || req.run_length > eff) begin
                  res_status <= bpa_pkg::ST_LEN;
                  state      <= S_DONE;
                end else begin
                  rem_q <= req.run_length;
                  state <= S_PCHK;
                end
              end
            endcase
          end
        end
        S_ORD: state <= S_OCHK;
        S_OCHK: begin
          if (&rdata) begin
            if (w_q == '1) begin
              res_status <= bpa_pkg::ST_NONE;
              state      <= S_DONE;
            end else begin
              w_q   <= w_q + 1'b1;
              state <= S_ORD;
            end
          end else begin
            free_cnt   <= free_cnt - 1'b1;
            res_addr   <= page_addr(base, {w_q, zpos});
            res_status <= bpa_pkg::ST_OK;
            state      <= S_DONE;
          end
        end
        S_PCHK: begin
          pidx_q <= diff[PS+IW-1:PS];
          if (page_ok) begin
            state <= S_PRW;
          end else begin
            res_status <= bpa_pkg::ST_ADDR;
            state      <= S_DONE;
          end
        end
        S_PRW: begin
          if (!rdata[pidx_q[BW-1:0]]) begin
            res_status <= bpa_pkg::ST_ADDR;
            state      <= S_DONE;
          end else begin
            free_cnt <= free_cnt + 1'b1;
            rem_q    <= rem_q - 1'b1;
            addr_q   <= addr_q + (AW+1)'(bpa_pkg::PAGE_BYTES);
            if (rem_q == CW'(1)) begin
              res_status <= bpa_pkg::ST_OK;
              state      <= S_DONE;
            end else begin
              state <= S_PCHK;
            end
          end
        end
        S_RRD: state <= S_RSCAN;
        S_RSCAN: begin
          if (run_n == len_q) begin
            end_q   <= i_q;
            start_q <= start_n[IW-1:0];
            w_q     <= start_n[IW-1:BW];
            state   <= S_MRD;
          end else if ({1'b0, i_q} + 1'b1 == eff) begin
            res_status <= bpa_pkg::ST_NONE;
            state      <= S_DONE;
          end else begin
            i_q   <= i_q + 1'b1;
            run_q <= run_n;
            if (i_q[BW-1:0] == '1) state <= S_RRD;
          end
        end
        S_MRD: state <= S_MWR;
        S_MWR: begin
          if (w_q == end_q[IW-1:BW]) begin
            free_cnt   <= free_cnt - len_q;
            res_addr   <= page_addr(base, start_q);
            res_status <= bpa_pkg::ST_OK;
            state      <= S_DONE;
          end else begin
            w_q   <= w_q + 1'b1;
            state <= S_MRD;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            out_valid  <= 1'b1;
            out_addr   <= res_addr;
            out_status <= res_status;
            out_free   <= free_cnt;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_cnt <= eff) else $error("free counter above page count");

  a_mem_port: assert property (@(posedge clk) disable iff (rst)
    !(mreq.re && mreq.we)) else $error("bitmap read and write together");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE)) else $error("accepted word left no work");

  a_fail_addr: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != bpa_pkg::ST_OK) |-> (rsp.result_address == '0))
    else $error("failed word carries an address");

endmodule
`default_nettype wire
